/* rtl/i2a_pkg.sv */
// ----------------------------------------------------------------------------
// Integer to ASCII converter package
// Shared widths, character codes, controller state type and digit lookup.
// ----------------------------------------------------------------------------
package i2a_pkg;

   localparam int VALUE_WIDTH = 32;

   // decimal digits needed for VALUE_WIDTH bits (also covers the hex digits)
   localparam int NUM_DEC  = (VALUE_WIDTH * 30103) / 100000 + 1;
   localparam int DEC_BITS = 4 * NUM_DEC;
   localparam int CNT_W    = $clog2(VALUE_WIDTH);
   localparam int POS_W    = $clog2(NUM_DEC);

   localparam logic [6:0] CHAR_ZERO  = 7'h30;
   localparam logic [6:0] CHAR_A     = 7'h41;
   localparam logic [6:0] CHAR_MINUS = 7'h2D;

   localparam logic REQ_DEC = 1'b0;
   localparam logic REQ_HEX = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONV,
      ST_SIGN,
      ST_EMIT
   } state_type;

   function automatic logic [6:0] digit_char(input logic [3:0] digit);
      logic [6:0] code;
      if (digit < 4'd10) begin
         code = CHAR_ZERO + {3'b000, digit};
      end else begin
         code = CHAR_A + {3'b000, digit - 4'd10};
      end
      return code;
   endfunction

endpackage

/* rtl/integer_to_ascii_converter_core.sv */
// ----------------------------------------------------------------------------
// Integer to ASCII converter core
// Converts one number to ASCII, signed decimal or unsigned upper-case hex.
//
// Request: present req_type and req_value with start high; the transfer
// happens at the edge where start is high and busy is low. busy stays high
// until the last character has been issued.
// Response: one character per rsp_strobe cycle, most significant first,
// leading zeros suppressed, '-' first for a negative decimal value, rsp_last
// on the final character. The receiver cannot stall; each character shows
// for exactly one cycle.
// Sequence: hex requests scan all NUM_DEC digit positions, the zero pad
// positions above the value included. Decimal requests pass through the
// serial binary to BCD unit, one bit per cycle, then the sign state when
// negative, then the scan of the NUM_DEC digit positions. A new request is
// taken only once the block is idle again after the final character.
// Reset: synchronous; the block returns idle and drops any conversion.
// ----------------------------------------------------------------------------
module integer_to_ascii_converter_core
   import i2a_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic                   req_type,
   input  logic [VALUE_WIDTH-1:0] req_value,
   output logic                   rsp_strobe,
   output logic [6:0]             rsp_out_char,
   output logic                   rsp_last
);

   state_type             state_ff, state_in;
   logic [DEC_BITS-1:0]   dig_ff, dig_in;
   logic [POS_W-1:0]      pos_ff, pos_in;
   logic                  started_ff, started_in;
   logic                  neg_ff, neg_in;
   logic                  strobe_ff, strobe_in;
   logic [6:0]            char_ff, char_in;
   logic                  last_ff, last_in;

   logic                  req_neg;
   logic [VALUE_WIDTH-1:0] req_mag;
   logic                  bcd_load;
   logic                  bcd_done;
   logic [DEC_BITS-1:0]   bcd_digits;
   logic [3:0]            top_digit;
   logic                  final_pos;

   assign req_neg   = (req_type == REQ_DEC) && req_value[VALUE_WIDTH-1];
   assign req_mag   = req_neg ? (~req_value + 1'b1) : req_value;
   assign top_digit = dig_ff[DEC_BITS-1 -: 4];
   assign final_pos = (pos_ff == POS_W'(NUM_DEC - 1));

   i2a_bcd u_bcd (
      .clock  (clock),
      .reset  (reset),
      .load   (bcd_load),
      .mag    (req_mag),
      .done   (bcd_done),
      .digits (bcd_digits)
   );

   always_comb begin
      state_in   = state_ff;
      dig_in     = dig_ff;
      pos_in     = pos_ff;
      started_in = started_ff;
      neg_in     = neg_ff;
      bcd_load   = 1'b0;
      strobe_in  = 1'b0;
      char_in    = digit_char(top_digit);
      last_in    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               neg_in     = req_neg;
               started_in = 1'b0;
               pos_in     = '0;
               if (req_type == REQ_HEX) begin
                  dig_in   = DEC_BITS'(req_value);
                  state_in = ST_EMIT;
               end else begin
                  bcd_load = 1'b1;
                  state_in = ST_CONV;
               end
            end
         end
         ST_CONV: begin
            if (bcd_done) begin
               dig_in   = bcd_digits;
               state_in = neg_ff ? ST_SIGN : ST_EMIT;
            end
         end
         ST_SIGN: begin
            strobe_in = 1'b1;
            char_in   = CHAR_MINUS;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            if ((top_digit != 4'd0) || started_ff || final_pos) begin
               strobe_in  = 1'b1;
               started_in = 1'b1;
               last_in    = final_pos;
            end
            dig_in = dig_ff << 4;
            pos_in = pos_ff + 1'b1;
            if (final_pos) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      dig_ff     <= dig_in;
      pos_ff     <= pos_in;
      started_ff <= started_in;
      neg_ff     <= neg_in;
      char_ff    <= char_in;
      last_ff    <= last_in;
   end

   assign busy         = (state_ff != ST_IDLE);
   assign rsp_strobe   = strobe_ff;
   assign rsp_out_char = char_ff;
   assign rsp_last     = last_ff;

endmodule

/* rtl/i2a_bcd.sv */
// ----------------------------------------------------------------------------
// Binary to BCD unit
// Shift-and-add-3 conversion, one magnitude bit per cycle, most significant bit first.
// ----------------------------------------------------------------------------
module i2a_bcd
   import i2a_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic [VALUE_WIDTH-1:0] mag,
   output logic                   done,
   output logic [DEC_BITS-1:0]    digits
);

   logic                   active_ff, active_in;
   logic                   done_ff, done_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic [VALUE_WIDTH-1:0] mag_ff, mag_in;
   logic [DEC_BITS-1:0]    bcd_ff, bcd_in;
   logic [DEC_BITS-1:0]    adj;

   always_comb begin
      for (int i = 0; i < NUM_DEC; i++) begin
         adj[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ? bcd_ff[4*i +: 4] + 4'd3
                                                     : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      mag_in    = mag_ff;
      bcd_in    = bcd_ff;
      if (load) begin
         active_in = 1'b1;
         cnt_in    = '0;
         mag_in    = mag;
         bcd_in    = '0;
      end else if (active_ff) begin
         bcd_in = {adj[DEC_BITS-2:0], mag_ff[VALUE_WIDTH-1]};
         mag_in = mag_ff << 1;
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == CNT_W'(VALUE_WIDTH - 1)) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      mag_ff <= mag_in;
      bcd_ff <= bcd_in;
   end

   assign done   = done_ff;
   assign digits = bcd_ff;

endmodule

/* rtl/i2a_checker.sv */
// ----------------------------------------------------------------------------
// Integer to ASCII converter port checker
// Port-level properties of the converter, bound to the converter core.
// ----------------------------------------------------------------------------
module i2a_checker
   import i2a_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_strobe,
   input logic [6:0]             rsp_out_char,
   input logic                   rsp_last
);

   // no character right after a request transfer
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> !rsp_strobe)
      else $error("character in cycle after request transfer");

   // the final character closes the response
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_last) |=> !rsp_strobe)
      else $error("character after final character");

   // a sign is never the final character
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_out_char == CHAR_MINUS)) |-> !rsp_last)
      else $error("minus sign flagged as last");

   // more characters pending means the block is still busy
   assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_last) |-> busy)
      else $error("idle with characters pending");

endmodule

bind integer_to_ascii_converter_core i2a_checker u_i2a_checker (
   .clock        (clock),
   .reset        (reset),
   .start        (start),
   .busy         (busy),
   .rsp_strobe   (rsp_strobe),
   .rsp_out_char (rsp_out_char),
   .rsp_last     (rsp_last)
);
